>>> hw/rtl/tile_bin_micropolygon_bound_top_assert.svh
// Assertion macros used by the tile binning checker.
`ifndef TILE_BIN_MICROPOLYGON_BOUND_TOP_ASSERT_SVH
`define TILE_BIN_MICROPOLYGON_BOUND_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBMB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBMB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tbmb_pkg.sv
// Shared types and constants of the tile binning block.
package tbmb_pkg;

	localparam int MAX_COLS    = 64;
	localparam int MAX_ROWS    = 64;
	localparam int TILE_W      = $clog2(MAX_COLS);
	localparam int CFG_W       = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_BIN   = 2'd0,
		OP_MARK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUCKETS_ACROSS = 3'd0,
		REG_BUCKETS_DOWN   = 3'd1,
		REG_FILTER_WIDTH_X = 3'd2,
		REG_FILTER_WIDTH_Y = 3'd3,
		REG_CROP_X_MIN     = 3'd4,
		REG_CROP_X_MAX     = 3'd5,
		REG_CROP_Y_MIN     = 3'd6,
		REG_CROP_Y_MAX     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [19:0] bound_min_x;
		logic signed [19:0] bound_min_y;
		logic signed [19:0] bound_max_x;
		logic signed [19:0] bound_max_y;
		logic [5:0]         mark_col;
		logic [5:0]         mark_row;
	} req_t;

	typedef struct packed {
		logic [5:0] tile_col;
		logic [5:0] tile_row;
		logic       last_tile;
		logic       trimmed;
	} tile_t;

	typedef struct packed {
		logic [6:0]         buckets_across;
		logic [6:0]         buckets_down;
		logic [9:0]         filter_width_x;
		logic [9:0]         filter_width_y;
		logic signed [19:0] crop_x_min;
		logic signed [19:0] crop_x_max;
		logic signed [19:0] crop_y_min;
		logic signed [19:0] crop_y_max;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_BIN   = 2'd0,
		JOB_MARK  = 2'd1,
		JOB_CLEAR = 2'd2
	} job_kind_t;

	// Work handed from the classifier to the tile walker. A mark job uses
	// col_lo and row_lo as the tile to mark.
	typedef struct packed {
		job_kind_t         kind;
		logic [TILE_W-1:0] col_lo;
		logic [TILE_W-1:0] col_hi;
		logic [TILE_W-1:0] row_lo;
		logic [TILE_W-1:0] row_hi;
		logic              trim;
	} job_t;

endpackage

>>> hw/rtl/tile_bin_micropolygon_bound_top.sv
// Top level of the screen tile binning block.
// A bin request passes the classifier stages and the job queue; the walker then reads the
// touched rows into its window and scans the clamped rectangle, busy until the last tile
// enters the output register. A mark reads and writes back one row; a clear resets the row flags.
// The classifier takes one request a cycle unless its last stage holds a job the queue refuses.
// Reset: configuration registers and control flags take their reset values; per-row valid flags clear the map.
module tile_bin_micropolygon_bound_top #(
	parameter int BUCKET_WIDTH  = 16,
	parameter int BUCKET_HEIGHT = 16,
	parameter int FRAC_BITS     = 4,
	parameter int MAX_SPAN      = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [tbmb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tbmb_pkg::CFG_W-1:0]       cfg_wdata,
	// request channel
	input  logic                             req_valid,
	output logic                             req_ready,
	input  tbmb_pkg::req_t                   req,
	// tile channel
	output logic                             tile_valid,
	input  logic                             tile_ready,
	output tbmb_pkg::tile_t                  tile
);

	tbmb_pkg::cfg_t cfg_q;
	logic           fq_valid, fq_ready, qb_valid, qb_ready;
	tbmb_pkg::job_t fq_job, qb_job;

	// Configuration registers. The user must write them only while the block is idle; the block
	// does not enforce it. The classifier reads them directly without any shadowing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buckets_across <= 7'd64;
			cfg_q.buckets_down   <= 7'd64;
			cfg_q.filter_width_x <= 10'd32;
			cfg_q.filter_width_y <= 10'd32;
			cfg_q.crop_x_min     <= 20'sd0;
			cfg_q.crop_x_max     <= 20'sd524287;
			cfg_q.crop_y_min     <= 20'sd0;
			cfg_q.crop_y_max     <= 20'sd524287;
		end else if (cfg_we) begin
			unique case (tbmb_pkg::cfg_reg_t'(cfg_idx))
				tbmb_pkg::REG_BUCKETS_ACROSS: cfg_q.buckets_across <= cfg_wdata[6:0];
				tbmb_pkg::REG_BUCKETS_DOWN:   cfg_q.buckets_down   <= cfg_wdata[6:0];
				tbmb_pkg::REG_FILTER_WIDTH_X: cfg_q.filter_width_x <= cfg_wdata[9:0];
				tbmb_pkg::REG_FILTER_WIDTH_Y: cfg_q.filter_width_y <= cfg_wdata[9:0];
				tbmb_pkg::REG_CROP_X_MIN:     cfg_q.crop_x_min     <= cfg_wdata;
				tbmb_pkg::REG_CROP_X_MAX:     cfg_q.crop_x_max     <= cfg_wdata;
				tbmb_pkg::REG_CROP_Y_MIN:     cfg_q.crop_y_min     <= cfg_wdata;
				tbmb_pkg::REG_CROP_Y_MAX:     cfg_q.crop_y_max     <= cfg_wdata;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Front: three-stage classifier. Crop test and filter growth, then the
	// reciprocal multiply for the tile division, then sign, grid reject,
	// clamp and span trim. Requests that yield nothing drop here.
	tbmb_front #(
		.BUCKET_WIDTH (BUCKET_WIDTH),
		.BUCKET_HEIGHT(BUCKET_HEIGHT),
		.FRAC_BITS    (FRAC_BITS),
		.MAX_SPAN     (MAX_SPAN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.job_valid(fq_valid),
		.job_ready(fq_ready),
		.job      (fq_job)
	);

	// Queue: decouples the classifier from the walker so new requests keep
	// flowing while a large rectangle is still being walked.
	tbmb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fq_valid),
		.push_ready(fq_ready),
		.push_job  (fq_job),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_job   (qb_job)
	);

	// Back: processed map in a row-wide RAM; loads the touched rows into a
	// small window, then scans column-major and holds one tile back so the
	// final one of a rectangle leaves flagged last.
	tbmb_back #(
		.MAX_SPAN(MAX_SPAN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.tile_valid(tile_valid),
		.tile_ready(tile_ready),
		.tile      (tile)
	);

endmodule

>>> hw/rtl/tbmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbmb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/tbmb_front.sv
// Classifier: crop test, filter growth, tile division, grid reject, clamp and span trim of each bin request.
module tbmb_front #(
	parameter int BUCKET_WIDTH  = 16,
	parameter int BUCKET_HEIGHT = 16,
	parameter int FRAC_BITS     = 4,
	parameter int MAX_SPAN      = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tbmb_pkg::cfg_t  cfg,
	input  logic            req_valid,
	output logic            req_ready,
	input  tbmb_pkg::req_t  req,
	output logic            job_valid,
	input  logic            job_ready,
	output tbmb_pkg::job_t  job
);

	localparam int TW    = tbmb_pkg::TILE_W;
	// doubled, grown coordinates fit in 23 signed bits; magnitudes below 2^21
	localparam int CW    = 23;
	localparam int NUM_W = 21;
	localparam int QW    = NUM_W + 1;
	localparam int MUL_W = NUM_W + 1;
	localparam int PW    = NUM_W + MUL_W;
	localparam int LX    = $clog2(BUCKET_WIDTH);
	localparam int LY    = $clog2(BUCKET_HEIGHT);
	localparam int SHX   = NUM_W + LX;
	localparam int SHY   = NUM_W + LY;
	localparam logic [MUL_W-1:0] RECIP_X = MUL_W'(((64'd1 << (NUM_W + LX)) +
		64'(BUCKET_WIDTH) - 64'd1) / 64'(BUCKET_WIDTH));
	localparam logic [MUL_W-1:0] RECIP_Y = MUL_W'(((64'd1 << (NUM_W + LY)) +
		64'(BUCKET_HEIGHT) - 64'd1) / 64'(BUCKET_HEIGHT));

	// edge order: min x, min y, max x, max y
	logic signed [CW-1:0] edge2 [4];
	logic signed [CW-1:0] flt   [4];
	logic signed [CW-1:0] grown [4];
	logic [CW-1:0]        absv  [4];
	logic signed [CW-1:0] crop_lo_x, crop_lo_y, crop_hi_x, crop_hi_y;
	logic                 keep_c;
	logic [NUM_W-1:0]     quo_c [4];

	logic                 vld_s1, vld_s2, vld_s3;
	logic [1:0]           op_s1, op_s2, op_s3;
	logic                 keep_s1, keep_s2, keep_s3;
	logic                 neg_s1 [4];
	logic                 neg_s2 [4];
	logic [NUM_W-1:0]     mag_s1 [4];
	logic [PW-1:0]        prod_s2 [4];
	logic signed [QW-1:0] quo_s3 [4];
	logic [TW-1:0]        mcol_s1, mcol_s2, mcol_s3;
	logic [TW-1:0]        mrow_s1, mrow_s2, mrow_s3;

	logic [6:0]           cols, rows;
	logic signed [QW-1:0] cols_s, rows_s;
	logic                 grid_rej, empty;
	logic [TW-1:0]        xa, xb, ya, yb, span_x, span_y;
	logic                 trim_x, trim_y;
	logic                 want;
	logic                 adv;

	always_comb begin
		edge2[0] = {(CW-1)'($signed(req.bound_min_x)), 1'b0};
		edge2[1] = {(CW-1)'($signed(req.bound_min_y)), 1'b0};
		edge2[2] = {(CW-1)'($signed(req.bound_max_x)), 1'b0};
		edge2[3] = {(CW-1)'($signed(req.bound_max_y)), 1'b0};
		flt[0]   = CW'(cfg.filter_width_x);
		flt[1]   = CW'(cfg.filter_width_y);
		flt[2]   = CW'(cfg.filter_width_x);
		flt[3]   = CW'(cfg.filter_width_y);
		crop_lo_x = {(CW-1)'($signed(cfg.crop_x_min)), 1'b0} - flt[0];
		crop_lo_y = {(CW-1)'($signed(cfg.crop_y_min)), 1'b0} - flt[1];
		crop_hi_x = {(CW-1)'($signed(cfg.crop_x_max)), 1'b0} + flt[0];
		crop_hi_y = {(CW-1)'($signed(cfg.crop_y_max)), 1'b0} + flt[1];
		keep_c = !(edge2[2] < crop_lo_x || edge2[3] < crop_lo_y ||
			edge2[0] > crop_hi_x || edge2[1] > crop_hi_y);
		grown[0] = edge2[0] - flt[0];
		grown[1] = edge2[1] - flt[1];
		grown[2] = edge2[2] + flt[2];
		grown[3] = edge2[3] + flt[3];
		for (int i = 0; i < 4; i++) begin
			absv[i] = grown[i][CW-1] ? -grown[i] : grown[i];
		end
	end

	// truncating division: quotient of the magnitude, sign restored in s3
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (i == 0 || i == 2) begin
				quo_c[i] = NUM_W'(prod_s2[i] >> SHX);
			end else begin
				quo_c[i] = NUM_W'(prod_s2[i] >> SHY);
			end
		end
	end

	always_comb begin
		cols = (cfg.buckets_across == 7'd0) ? 7'd1 :
			((cfg.buckets_across > 7'(tbmb_pkg::MAX_COLS)) ? 7'(tbmb_pkg::MAX_COLS) :
			cfg.buckets_across);
		rows = (cfg.buckets_down == 7'd0) ? 7'd1 :
			((cfg.buckets_down > 7'(tbmb_pkg::MAX_ROWS)) ? 7'(tbmb_pkg::MAX_ROWS) :
			cfg.buckets_down);
		cols_s = QW'(cols);
		rows_s = QW'(rows);
		grid_rej = quo_s3[2] < 0 || quo_s3[3] < 0 || quo_s3[0] >= cols_s ||
			quo_s3[1] >= rows_s;
		xa = (quo_s3[0] < 0) ? '0 : TW'(quo_s3[0]);
		ya = (quo_s3[1] < 0) ? '0 : TW'(quo_s3[1]);
		xb = (quo_s3[2] >= cols_s) ? TW'(cols - 7'd1) : TW'(quo_s3[2]);
		yb = (quo_s3[3] >= rows_s) ? TW'(rows - 7'd1) : TW'(quo_s3[3]);
		// inverted rectangles touch nothing
		empty  = (xa > xb) || (ya > yb);
		span_x = xb - xa;
		span_y = yb - ya;
		trim_x = {1'b0, span_x} >= (TW+1)'(MAX_SPAN);
		trim_y = {1'b0, span_y} >= (TW+1)'(MAX_SPAN);

		job = '0;
		want = 1'b0;
		unique case (op_s3)
			tbmb_pkg::OP_BIN: begin
				want = keep_s3 && !grid_rej && !empty;
				job.kind = tbmb_pkg::JOB_BIN;
				job.col_lo = xa;
				job.row_lo = ya;
				job.col_hi = trim_x ? xa + TW'(MAX_SPAN - 1) : xb;
				job.row_hi = trim_y ? ya + TW'(MAX_SPAN - 1) : yb;
				job.trim = trim_x || trim_y;
			end
			tbmb_pkg::OP_MARK: begin
				want = 1'b1;
				job.kind = tbmb_pkg::JOB_MARK;
				job.col_lo = mcol_s3;
				job.row_lo = mrow_s3;
			end
			tbmb_pkg::OP_CLEAR: begin
				want = 1'b1;
				job.kind = tbmb_pkg::JOB_CLEAR;
			end
			default: begin
				want = 1'b0;
			end
		endcase
	end

	// drop work that yields nothing without waiting on the queue
	assign adv       = !vld_s3 || !want || job_ready;
	assign req_ready = adv;
	assign job_valid = vld_s3 && want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= req.opcode;
			keep_s1 <= keep_c;
			mcol_s1 <= req.mark_col;
			mrow_s1 <= req.mark_row;
			for (int i = 0; i < 4; i++) begin
				neg_s1[i] <= grown[i][CW-1];
				mag_s1[i] <= NUM_W'(absv[i] >> (FRAC_BITS + 1));
			end

			op_s2   <= op_s1;
			keep_s2 <= keep_s1;
			mcol_s2 <= mcol_s1;
			mrow_s2 <= mrow_s1;
			for (int i = 0; i < 4; i++) begin
				neg_s2[i] <= neg_s1[i];
				if (i == 0 || i == 2) begin
					prod_s2[i] <= PW'(mag_s1[i]) * PW'(RECIP_X);
				end else begin
					prod_s2[i] <= PW'(mag_s1[i]) * PW'(RECIP_Y);
				end
			end

			op_s3   <= op_s2;
			keep_s3 <= keep_s2;
			mcol_s3 <= mcol_s2;
			mrow_s3 <= mrow_s2;
			for (int i = 0; i < 4; i++) begin
				quo_s3[i] <= neg_s2[i] ? -QW'(quo_c[i]) : QW'(quo_c[i]);
			end
		end
	end

endmodule

>>> hw/rtl/tbmb_queue.sv
// Short job queue between the classifier and the tile walker.
module tbmb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tbmb_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tbmb_pkg::job_t pop_job
);

	localparam int DEPTH = tbmb_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tbmb_pkg::job_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> hw/rtl/tbmb_back.sv
// Tile walker: keeps the processed map and emits unprocessed tiles of a job.
module tbmb_back #(
	parameter int MAX_SPAN = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  tbmb_pkg::job_t  job,
	output logic            tile_valid,
	input  logic            tile_ready,
	output tbmb_pkg::tile_t tile
);

	localparam int TW   = tbmb_pkg::TILE_W;
	localparam int NC   = tbmb_pkg::MAX_COLS;
	localparam int NR   = tbmb_pkg::MAX_ROWS;
	localparam int SI_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MARK  = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_WAIT  = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t              state_q;
	logic [NR-1:0]       row_vld_q;
	logic [TW-1:0]       col_lo_q, col_hi_q, row_lo_q, row_hi_q;
	logic                trim_q;
	logic [TW-1:0]       ld_cnt_q, ld_row_q;
	logic                ld_vld_q;
	logic [MAX_SPAN-1:0] span_q [MAX_SPAN];
	logic [TW-1:0]       sc_col_q, sc_row_q;
	logic                cand_vld_q;
	logic [TW-1:0]       cand_col_q, cand_row_q;
	logic                out_vld_q;
	tbmb_pkg::tile_t     out_q;

	logic                take;
	logic                ld_issue;
	logic                ram_re, ram_we;
	logic [TW-1:0]       ram_raddr;
	logic [NC-1:0]       ram_rdata, ram_wdata, rd_row, mark_row_data;
	logic [MAX_SPAN-1:0] rd_bits;
	logic [SI_W-1:0]     ld_slot, sc_slot, sc_bit;
	logic                pending, out_free, step, at_end;
	logic                emit_mid, emit_last, emit;

	assign job_ready = state_q == ST_IDLE;
	assign take      = job_valid && job_ready;
	assign ld_issue  = (take && job.kind == tbmb_pkg::JOB_BIN) || state_q == ST_LOAD;

	always_comb begin
		ram_re    = ld_issue || (take && job.kind == tbmb_pkg::JOB_MARK);
		ram_raddr = (state_q == ST_LOAD) ? ld_cnt_q : job.row_lo;
	end

	// a row never written since the last clear reads as all unprocessed
	assign mark_row_data = row_vld_q[row_lo_q] ? ram_rdata : '0;
	assign ram_we    = state_q == ST_MARK;
	assign ram_wdata = mark_row_data | ({{(NC-1){1'b0}}, 1'b1} << col_lo_q);

	assign rd_row  = row_vld_q[ld_row_q] ? ram_rdata : '0;
	assign rd_bits = MAX_SPAN'(rd_row >> col_lo_q);
	assign ld_slot = SI_W'(ld_row_q - row_lo_q);

	assign sc_slot   = SI_W'(sc_row_q - row_lo_q);
	assign sc_bit    = SI_W'(sc_col_q - col_lo_q);
	assign pending   = !span_q[sc_slot][sc_bit];
	assign out_free  = !out_vld_q || tile_ready;
	assign at_end    = sc_col_q == col_hi_q && sc_row_q == row_hi_q;
	// hold the scan when the held tile must leave but the output is full
	assign step      = !(pending && cand_vld_q && !out_free);
	assign emit_mid  = state_q == ST_SCAN && step && pending && cand_vld_q;
	assign emit_last = state_q == ST_FLUSH && cand_vld_q && out_free;
	assign emit      = emit_mid || emit_last;

	tbmb_ram #(
		.WIDTH(NC),
		.DEPTH(NR)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(row_lo_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_vld_q  <= '0;
			ld_vld_q   <= 1'b0;
			cand_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			ld_vld_q <= ld_issue;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (tile_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						unique case (job.kind)
							tbmb_pkg::JOB_CLEAR: begin
								row_vld_q <= '0;
							end
							tbmb_pkg::JOB_MARK: begin
								state_q <= ST_MARK;
							end
							tbmb_pkg::JOB_BIN: begin
								cand_vld_q <= 1'b0;
								state_q <= (job.row_lo == job.row_hi) ? ST_WAIT : ST_LOAD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MARK: begin
					row_vld_q[row_lo_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					if (ld_cnt_q == row_hi_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (step) begin
						if (pending) begin
							cand_vld_q <= 1'b1;
						end
						if (at_end) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!cand_vld_q || out_free) begin
						cand_vld_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_lo_q <= job.col_lo;
			col_hi_q <= job.col_hi;
			row_lo_q <= job.row_lo;
			row_hi_q <= job.row_hi;
			trim_q   <= job.trim;
			ld_cnt_q <= job.row_lo + 1'b1;
			sc_col_q <= job.col_lo;
			sc_row_q <= job.row_lo;
		end else if (state_q == ST_LOAD) begin
			ld_cnt_q <= ld_cnt_q + 1'b1;
		end
		ld_row_q <= ram_raddr;
		if (ld_vld_q) begin
			span_q[ld_slot] <= rd_bits;
		end
		if (state_q == ST_SCAN && step) begin
			if (pending) begin
				cand_col_q <= sc_col_q;
				cand_row_q <= sc_row_q;
			end
			if (sc_row_q == row_hi_q) begin
				sc_row_q <= row_lo_q;
				sc_col_q <= sc_col_q + 1'b1;
			end else begin
				sc_row_q <= sc_row_q + 1'b1;
			end
		end
		if (emit) begin
			out_q.tile_col  <= cand_col_q;
			out_q.tile_row  <= cand_row_q;
			out_q.last_tile <= emit_last;
			out_q.trimmed   <= trim_q;
		end
	end

	assign tile_valid = out_vld_q;
	assign tile       = out_q;

endmodule

>>> hw/rtl/tbmb_checker.sv
// Port-level checker of the tile binning block and its bind.
`include "tile_bin_micropolygon_bound_top_assert.svh"

module tbmb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            tile_valid,
	input logic            tile_ready,
	input tbmb_pkg::tile_t tile
);

	logic       mid_q;
	logic       trim_q;
	logic [5:0] prev_col_q, prev_row_q;

	// track the tiles already delivered for the current rectangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (tile_valid && tile_ready) begin
			mid_q <= !tile.last_tile;
		end
	end

	always_ff @(posedge clk) begin
		if (tile_valid && tile_ready) begin
			trim_q     <= tile.trimmed;
			prev_col_q <= tile.tile_col;
			prev_row_q <= tile.tile_row;
		end
	end

	`TBMB_ASSERT_NEXT(a_tile_hold, tile_valid && !tile_ready, tile_valid && $stable(tile), "tile changed while stalled")
	`TBMB_ASSERT_SAME(a_trim_same, tile_valid && mid_q, tile.trimmed == trim_q, "trimmed flag changed within a rectangle")
	`TBMB_ASSERT_SAME(a_col_major, tile_valid && mid_q, (tile.tile_col > prev_col_q) || (tile.tile_col == prev_col_q && tile.tile_row > prev_row_q), "tiles out of column-major order")

endmodule

bind tile_bin_micropolygon_bound_top tbmb_checker u_tbmb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tile_valid(tile_valid),
	.tile_ready(tile_ready),
	.tile      (tile)
);
